// ===== hdl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types for the point-in-polygon crossing test: item commands,
// controller states and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_VERTEX = 2'd1,
    CMD_END    = 2'd2
  } item_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP
  } ctrl_state_t;

  typedef struct packed {
    logic begin_load;
    logic vertex_first;
    logic vertex_edge;
    logic close_edge;
    logic multiply;
    logic parity_update;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic seen_vertex;
  } dp_sts_t;

endpackage

// ===== hdl/pip_in_if.sv =====
// ----------------------------------------------------------------------------
// pip_in_if
// Input channel: command and coordinate pair with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, cmd, coord_x, coord_y, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, output ready);
endinterface

// ===== hdl/pip_out_if.sv =====
// ----------------------------------------------------------------------------
// pip_out_if
// Output channel: one inside/outside flag per end item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// ===== hdl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a test point against a streamed polygon.
// ----------------------------------------------------------------------------
// A begin transaction takes the test point and clears the polygon; vertex
// transactions follow in order; an end transaction tests the closing edge and
// returns one inside flag (0 when there are no vertices or the point lies
// outside the vertex bounding box). Begin, unused commands and the first
// vertex are taken straight from the idle state. Every later vertex and every
// end goes through the shared edge unit in order: the edge differences, the
// two cross products, then the exact signed compare.
// An end also waits in its compare step while a previous answer is untaken.
module point_in_polygon_test #(
  parameter int COORD_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  pip_in_if.sink   req,
  pip_out_if.source rsp
);
  import pip_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_cmd    (req.cmd),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  pip_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts),
    .coord_x    (req.coord_x),
    .coord_y    (req.coord_y),
    .inside_res (rsp.inside_res)
  );

endmodule

// ===== hdl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller: sequences each edge test through difference, multiply and
// compare steps and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pip_pkg::dp_cmd_t dp_cmd,
  input  pip_pkg::dp_sts_t dp_sts
);
  import pip_pkg::*;

  ctrl_state_t state, state_next;
  logic        is_end, is_end_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      is_end    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      is_end    <= is_end_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    is_end_next = is_end;
    dp_cmd      = '0;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_BEGIN: begin
              dp_cmd.begin_load = 1'b1;
            end
            CMD_VERTEX: begin
              if (dp_sts.seen_vertex) begin
                dp_cmd.vertex_edge = 1'b1;
                is_end_next        = 1'b0;
                state_next         = ST_MUL;
              end else begin
                dp_cmd.vertex_first = 1'b1;
              end
            end
            CMD_END: begin
              dp_cmd.close_edge = 1'b1;
              is_end_next       = 1'b1;
              state_next        = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        dp_cmd.multiply = 1'b1;
        state_next      = ST_CMP;
      end
      ST_CMP: begin
        if (!is_end) begin
          dp_cmd.parity_update = 1'b1;
          state_next           = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          dp_cmd.result_load = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = (out_valid && !out_ready) || dp_cmd.result_load;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.result_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken transaction");

  a_mul_then_cmp: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_CMP)
    else $error("multiply step not followed by compare");

  a_end_starts_edge: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_cmd == CMD_END) |=> (state == ST_MUL && is_end))
    else $error("end transaction did not start closing edge");

  a_first_vertex_once: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.vertex_first |=> dp_sts.seen_vertex)
    else $error("first vertex not recorded");

  a_result_only_on_end: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.result_load |-> (state == ST_CMP && is_end))
    else $error("result outside end sequence");

endmodule

// ===== hdl/pip_dp.sv =====
// ----------------------------------------------------------------------------
// pip_dp
// Datapath: polygon state, bounding box, edge differences, exact cross
// products and the crossing compare.
// ----------------------------------------------------------------------------
module pip_dp #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_pkg::dp_cmd_t             dp_cmd,
  output pip_pkg::dp_sts_t             dp_sts,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         inside_res
);
  import pip_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] test_x, test_y, first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic                         crossing_parity, seen_vertex;

  logic signed [COORD_BITS-1:0] xi, yi;
  logic signed [D-1:0]          da, db, dc, dd;
  logic                         straddle, straddle_m, dd_pos;
  logic signed [P-1:0]          prod_p, prod_q;
  logic                         less, counts, outside;
  logic                         vertex_upd;

  assign xi         = dp_cmd.close_edge ? first_x : coord_x;
  assign yi         = dp_cmd.close_edge ? first_y : coord_y;
  assign vertex_upd = dp_cmd.vertex_first || dp_cmd.vertex_edge;

  // polygon state
  always_ff @(posedge clk) begin
    if (rst || dp_cmd.begin_load) begin
      first_x         <= '0;
      first_y         <= '0;
      prev_x          <= '0;
      prev_y          <= '0;
      box_min_x       <= CMAX;
      box_min_y       <= CMAX;
      box_max_x       <= CMIN;
      box_max_y       <= CMIN;
      crossing_parity <= 1'b0;
      seen_vertex     <= 1'b0;
    end else begin
      if (dp_cmd.vertex_first) begin
        first_x     <= coord_x;
        first_y     <= coord_y;
        seen_vertex <= 1'b1;
      end
      if (vertex_upd) begin
        prev_x <= coord_x;
        prev_y <= coord_y;
        if (coord_x < box_min_x) box_min_x <= coord_x;
        if (coord_x > box_max_x) box_max_x <= coord_x;
        if (coord_y < box_min_y) box_min_y <= coord_y;
        if (coord_y > box_max_y) box_max_y <= coord_y;
      end
      if (dp_cmd.parity_update && counts) begin
        crossing_parity <= !crossing_parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_x <= '0;
      test_y <= '0;
    end else if (dp_cmd.begin_load) begin
      test_x <= coord_x;
      test_y <= coord_y;
    end
  end

  // edge differences, then products
  always_ff @(posedge clk) begin
    if (dp_cmd.vertex_edge || dp_cmd.close_edge) begin
      da       <= D'(test_x) - D'(xi);
      db       <= D'(prev_x) - D'(xi);
      dc       <= D'(test_y) - D'(yi);
      dd       <= D'(prev_y) - D'(yi);
      straddle <= (yi > test_y) != (prev_y > test_y);
    end
    if (dp_cmd.multiply) begin
      prod_p     <= P'(da) * P'(dd);
      prod_q     <= P'(db) * P'(dc);
      dd_pos     <= dd > 0;
      straddle_m <= straddle;
    end
  end

  assign less    = dd_pos ? (prod_p < prod_q) : (prod_q < prod_p);
  assign counts  = straddle_m && less;
  assign outside = !seen_vertex || test_x < box_min_x || test_x > box_max_x ||
                   test_y < box_min_y || test_y > box_max_y;

  always_ff @(posedge clk) begin
    if (dp_cmd.result_load) begin
      inside_res <= !outside && (crossing_parity ^ counts);
    end
  end

  assign dp_sts.seen_vertex = seen_vertex;

endmodule
